// File: design/pss_pkg.sv
`default_nettype none

package pss_pkg;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_REDUCE,
        ST_FINISH
    } t_state;

    // First candidate of every run, and the value expected right after reset.
    localparam int FIRST_CANDIDATE = 2;

    // The hit reduction folds OR_FANIN bits into one per cycle of the reduction; this value is log2 of that fan-in.
    localparam int OR_FANIN_LOG = 4;
    localparam int OR_FANIN     = 1 << OR_FANIN_LOG;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic clear;     // zero the remainder before a serial remainder pass or at the wrap to zero
        logic mod_step;  // one bit step of the serial remainder pass
        logic mod_bit;   // candidate bit that this step shifts in
        logic advance;   // move the remainder on to the next candidate
        logic shift;     // take prime and remainder from the previous cell
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: design/pss_cell.sv
`default_nettype none

module pss_cell #(
    parameter int VALUE_BITS = 24,
    parameter int STORE_BITS = 12,
    parameter int COUNT_BITS = 11,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  pss_pkg::t_cell_ctrl   i_ctrl,
    input  logic [VALUE_BITS-1:0] i_candidate,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [STORE_BITS-1:0] i_prev_prime,
    input  logic [STORE_BITS-1:0] i_prev_rem,
    output logic [STORE_BITS-1:0] o_prime,
    output logic [STORE_BITS-1:0] o_rem_next,
    output logic                  o_hit
);
    import pss_pkg::*;

    logic [STORE_BITS-1:0] r_prime;
    logic [STORE_BITS-1:0] r_rem;
    logic [STORE_BITS:0]   rem_plus;
    logic [STORE_BITS:0]   mod_shift;
    logic [STORE_BITS-1:0] mod_next;

    // Remainder of the following candidate: count up and wrap at the prime.
    always_comb begin
        rem_plus = {1'b0, r_rem} + (STORE_BITS + 1)'(1);
        if (rem_plus == {1'b0, r_prime}) begin
            o_rem_next = '0;
        end else begin
            o_rem_next = rem_plus[STORE_BITS-1:0];
        end
    end

    // One restoring step of the serial remainder: double, add a bit, subtract once.
    always_comb begin
        mod_shift = {r_rem, i_ctrl.mod_bit};
        if (mod_shift >= {1'b0, r_prime}) begin
            mod_shift = mod_shift - {1'b0, r_prime};
        end
        mod_next = mod_shift[STORE_BITS-1:0];
    end

    // Prime and remainder registers of this slot.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_prime <= i_prev_prime;
            r_rem   <= i_prev_rem;
        end else if (i_ctrl.advance) begin
            r_rem <= o_rem_next;
        end else if (i_ctrl.clear) begin
            r_rem <= '0;
        end else if (i_ctrl.mod_step) begin
            r_rem <= mod_next;
        end
    end

    // A filled slot divides the candidate when the remainder is zero and the
    // prime is not the candidate itself.
    assign o_hit = (i_count > COUNT_BITS'(INDEX)) && (r_rem == '0)
                   && (VALUE_BITS'(r_prime) != i_candidate);

    assign o_prime = r_prime;

endmodule

`default_nettype wire

// File: design/pss_or_tree.sv
`default_nettype none

module pss_or_tree #(
    parameter int WIDTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [WIDTH-1:0] i_hits,
    output logic             o_any
);
    import pss_pkg::*;

    logic [WIDTH-1:0] r_vec;
    logic [WIDTH-1:0] n_vec;

    // One tree level per step: each bit becomes the OR of one group of bits.
    always_comb begin
        for (int i = 0; i < WIDTH; i++) begin
            n_vec[i] = 1'b0;
            for (int j = 0; j < OR_FANIN; j++) begin
                if (i * OR_FANIN + j < WIDTH) begin
                    n_vec[i] = n_vec[i] | r_vec[i * OR_FANIN + j];
                end
            end
        end
    end

    // The same register holds every level of the tree in turn.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vec <= i_hits;
        end else if (i_step) begin
            r_vec <= n_vec;
        end
    end

    assign o_any = r_vec[0];

endmodule

`default_nettype wire

// File: design/prime_sieve_stream_core.sv
`default_nettype none

// Channel   Direction  tdata (low bit up)    tuser (low bit up)
// s_axis    in         candidate             restart
// m_axis    out        sieve_value           is_prime, sequence_error
//
// A candidate that follows its predecessor goes from its transfer through the check
// step, the levels of the hit reduction over the cell chain and the final step into
// the output register; the next candidate is taken once the core is back in idle,
// so the core works on one candidate at a time.
// An out-of-sequence candidate without restart first runs a bit-serial remainder pass
// over its VALUE_BITS bits, which all cells run in parallel.
// Reset is synchronous and empties the store through the fill count alone.
// A new candidate is taken while the previous result still waits in the output
// register; a result that cannot leave holds the core in its final step.

module prime_sieve_stream_core #(
    parameter int VALUE_BITS  = 24,
    parameter int PRIME_SLOTS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // candidate
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // restart
    input  logic [0:0]                           s_axis_tuser,
    // sieve_value
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((VALUE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    // is_prime, sequence_error
    output logic [1:0]                           m_axis_tuser
);
    import pss_pkg::*;

    localparam int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int STORE_BITS = (VALUE_BITS + 1) / 2;
    localparam int COUNT_BITS = $clog2(PRIME_SLOTS + 1);
    localparam int STEP_BITS  = $clog2(VALUE_BITS);
    localparam int RED_LEVELS = ($clog2(PRIME_SLOTS) + OR_FANIN_LOG - 1) / OR_FANIN_LOG;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_cand, n_cand;
    logic                  r_err, n_err;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [VALUE_BITS-1:0] r_expected, n_expected;
    logic [STEP_BITS-1:0]  r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0] r_out_value, n_out_value;
    logic                  r_out_prime, n_out_prime;
    logic                  r_out_err, n_out_err;

    t_cell_ctrl            cell_ctrl;
    logic                  tree_load;
    logic                  tree_step;
    logic                  any_hit;
    logic [PRIME_SLOTS-1:0] hits;
    logic [STORE_BITS-1:0] cell_prime [PRIME_SLOTS];
    logic [STORE_BITS-1:0] cell_rem   [PRIME_SLOTS];

    logic [VALUE_BITS-1:0] in_cand;
    logic                  in_restart;
    logic                  in_err;
    logic                  is_prime;
    logic                  fits_slot;
    logic                  store;

    assign in_cand    = s_axis_tdata[VALUE_BITS-1:0];
    assign in_restart = s_axis_tuser[0];

    // Sequence check of the incoming candidate.
    assign in_err = in_restart ? (in_cand != VALUE_BITS'(FIRST_CANDIDATE))
                               : (in_cand != r_expected);

    // Verdict and store decision for the candidate at hand.
    assign is_prime  = (r_cand > VALUE_BITS'(1)) && !any_hit;
    assign fits_slot = (r_cand >> STORE_BITS) == '0;
    assign store     = is_prime && !r_err && fits_slot
                       && (r_count < COUNT_BITS'(PRIME_SLOTS));

    // Chain of prime cells; a new prime enters at the head and the rest move on.
    for (genvar k = 0; k < PRIME_SLOTS; k++) begin : g_cell
        logic [STORE_BITS-1:0] prev_prime;
        logic [STORE_BITS-1:0] prev_rem;

        if (k == 0) begin : g_head
            assign prev_prime = r_cand[STORE_BITS-1:0];
            assign prev_rem   = STORE_BITS'(1);
        end else begin : g_link
            assign prev_prime = cell_prime[k-1];
            assign prev_rem   = cell_rem[k-1];
        end

        pss_cell #(
            .VALUE_BITS (VALUE_BITS),
            .STORE_BITS (STORE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .INDEX      (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_candidate  (r_cand),
            .i_count      (r_count),
            .i_prev_prime (prev_prime),
            .i_prev_rem   (prev_rem),
            .o_prime      (cell_prime[k]),
            .o_rem_next   (cell_rem[k]),
            .o_hit        (hits[k])
        );
    end

    // Registered OR of all cell hits.
    pss_or_tree #(
        .WIDTH (PRIME_SLOTS)
    ) u_or_tree (
        .i_clk  (i_clk),
        .i_load (tree_load),
        .i_step (tree_step),
        .i_hits (hits),
        .o_any  (any_hit)
    );

    // Next state, cell control and result capture.
    always_comb begin
        n_state     = r_state;
        n_cand      = r_cand;
        n_err       = r_err;
        n_count     = r_count;
        n_expected  = r_expected;
        n_step      = r_step;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_value = r_out_value;
        n_out_prime = r_out_prime;
        n_out_err   = r_out_err;
        cell_ctrl   = '0;
        tree_load   = 1'b0;
        tree_step   = 1'b0;
        s_axis_tready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = i_rst_n;
                if (s_axis_tvalid && i_rst_n) begin
                    n_cand = in_cand;
                    n_err  = in_err;
                    if (in_restart) begin
                        n_count = '0;
                    end
                    if (!in_restart && (in_cand != r_expected)) begin
                        cell_ctrl.clear = 1'b1;
                        n_step  = STEP_BITS'(VALUE_BITS - 1);
                        n_state = ST_MOD;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_MOD: begin
                cell_ctrl.mod_step = 1'b1;
                cell_ctrl.mod_bit  = r_cand[r_step];
                if (r_step == '0) begin
                    n_state = ST_CHECK;
                end else begin
                    n_step = r_step - STEP_BITS'(1);
                end
            end
            ST_CHECK: begin
                tree_load = 1'b1;
                n_step    = STEP_BITS'(RED_LEVELS - 1);
                n_state   = ST_REDUCE;
            end
            ST_REDUCE: begin
                tree_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_FINISH;
                end else begin
                    n_step = r_step - STEP_BITS'(1);
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid       = 1'b1;
                    n_out_value       = is_prime ? r_cand : '0;
                    n_out_prime       = is_prime;
                    n_out_err         = r_err;
                    n_expected        = r_cand + VALUE_BITS'(1);
                    // Past the top of the range the next candidate is zero, so every
                    // remainder starts over at zero instead of counting up.
                    if (r_cand == '1) begin
                        cell_ctrl.clear = 1'b1;
                    end else begin
                        cell_ctrl.advance = 1'b1;
                    end
                    cell_ctrl.shift   = store;
                    if (store) begin
                        n_count = r_count + COUNT_BITS'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_expected  <= VALUE_BITS'(FIRST_CANDIDATE);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_expected  <= n_expected;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cand      <= n_cand;
        r_err       <= n_err;
        r_step      <= n_step;
        r_out_value <= n_out_value;
        r_out_prime <= n_out_prime;
        r_out_err   <= n_out_err;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DATA_BITS'(r_out_value);
    assign m_axis_tuser  = {r_out_err, r_out_prime};

endmodule

`default_nettype wire

// File: design/pss_checker.sv
`default_nettype none

module pss_checker #(
    parameter int VALUE_BITS = 24
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 i_s_axis_tready,
    input logic                                 i_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [((VALUE_BITS + 7) / 8) * 8-1:0] i_m_axis_tdata,
    input logic [1:0]                           i_m_axis_tuser
);

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result valid after reset");

    // The prime flag and a nonzero sieve value always agree.
    a_prime_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |->
            (i_m_axis_tuser[0] == (i_m_axis_tdata[VALUE_BITS-1:0] != '0)))
        else $error("prime flag disagrees with sieve value");

    // The core works on one candidate at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tready |=> !i_s_axis_tready)
        else $error("second candidate taken while one is at work");

endmodule

bind prime_sieve_stream_core pss_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_pss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (s_axis_tvalid),
    .i_s_axis_tready (s_axis_tready),
    .i_m_axis_tvalid (m_axis_tvalid),
    .i_m_axis_tready (m_axis_tready),
    .i_m_axis_tdata  (m_axis_tdata),
    .i_m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: dv/tb_prime_sieve_stream_core.sv
`default_nettype none

module tb_prime_sieve_stream_core;

    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    localparam int VALUE_BITS  = 24;
    localparam int PRIME_SLOTS = 1024;
    localparam int STORE_BITS  = (VALUE_BITS + 1) / 2;
    localparam int DATA_BITS   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int STORE_LIMIT = 1 << STORE_BITS;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 470;

    localparam bit PINNED    = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef logic [VALUE_BITS-1:0] t_value;

    // One classification leaving the core.
    typedef struct packed {
        t_value sieve_value;
        logic   is_prime;
        logic   seq_error;
    } t_sieve_result;

    // One row of the directed stimulus; pinned rows carry a hand-written result.
    typedef struct packed {
        t_value        candidate;
        logic          restart;
        logic          pinned;
        t_sieve_result want;
    } t_stimulus_row;

    localparam int DIRECTED_ROWS = 24;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [DATA_BITS-1:0] s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [DATA_BITS-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    // Predictor state: the primes kept so far and the next candidate in sequence.
    logic [STORE_BITS-1:0] stored_primes [PRIME_SLOTS];
    int                    stored_count;
    t_value                next_candidate;

    t_sieve_result pending_results [$];
    int            mismatch_count;
    int            items_sent;
    int            sender_idle_pct;
    int            receiver_idle_pct;
    int unsigned   cycle_count;

    t_stimulus_row directed_table [DIRECTED_ROWS] = '{
        // Opening run after reset, then a gap that the store marks composite.
        '{24'd2,        1'b0, PINNED,    '{24'd2, 1'b1, 1'b0}},
        '{24'd3,        1'b0, PINNED,    '{24'd3, 1'b1, 1'b0}},
        '{24'd4,        1'b0, PINNED,    '{24'd0, 1'b0, 1'b0}},
        '{24'd5,        1'b0, PREDICTED, '0},
        '{24'd6,        1'b0, PREDICTED, '0},
        '{24'd7,        1'b0, PREDICTED, '0},
        '{24'd9,        1'b0, PINNED,    '{24'd0, 1'b0, 1'b1}},
        '{24'd10,       1'b0, PREDICTED, '0},
        '{24'd11,       1'b0, PREDICTED, '0},
        // A stored prime is never its own divisor.
        '{24'd3,        1'b0, PINNED,    '{24'd3, 1'b1, 1'b1}},
        // Candidates below two are composite.
        '{24'd0,        1'b0, PINNED,    '{24'd0, 1'b0, 1'b1}},
        '{24'd1,        1'b0, PINNED,    '{24'd0, 1'b0, 1'b0}},
        '{24'd2,        1'b0, PREDICTED, '0},
        // Largest candidate, then the wrap back to zero.
        '{24'hFFFFFF,   1'b0, PINNED,    '{24'd0, 1'b0, 1'b1}},
        '{24'd0,        1'b0, PINNED,    '{24'd0, 1'b0, 1'b0}},
        // Restart on the wrong candidate still empties the store.
        '{24'd5,        1'b1, PINNED,    '{24'd5, 1'b1, 1'b1}},
        '{24'd6,        1'b0, PREDICTED, '0},
        '{24'd2,        1'b1, PINNED,    '{24'd2, 1'b1, 1'b0}},
        '{24'd3,        1'b0, PREDICTED, '0},
        '{24'd4,        1'b0, PREDICTED, '0},
        '{24'hFFFFFF,   1'b1, PINNED,    '{24'hFFFFFF, 1'b1, 1'b1}},
        // Candidates too wide for a store slot are reported prime by the empty store but not kept.
        '{24'h800000,   1'b0, PREDICTED, '0},
        '{24'h800001,   1'b0, PREDICTED, '0},
        '{24'd2,        1'b1, PINNED,    '{24'd2, 1'b1, 1'b0}}
    };

    prime_sieve_stream_core #(
        .VALUE_BITS  (VALUE_BITS),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle counter that ends a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Classify one candidate and advance the predictor state.
    function automatic t_sieve_result sieve_predict(input t_value cand, input logic restart_flag);
        t_sieve_result res;
        logic          seq_err;
        logic          prime;
        t_value        divisor;
        if (restart_flag) begin
            stored_count = 0;
            seq_err = (cand != t_value'(FIRST_CANDIDATE));
        end else begin
            seq_err = (cand != next_candidate);
        end
        prime = (cand >= 2);
        for (int k = 0; k < stored_count; k++) begin
            divisor = t_value'(stored_primes[k]);
            if (divisor >= 2 && divisor < cand && (cand % divisor) == 0)
                prime = 1'b0;
        end
        // Only primes from an in-sequence step that fit a slot are kept.
        if (prime && !seq_err && cand < STORE_LIMIT && stored_count < PRIME_SLOTS) begin
            stored_primes[stored_count] = cand[STORE_BITS-1:0];
            stored_count++;
        end
        next_candidate = cand + 1'b1;
        res.sieve_value = prime ? cand : '0;
        res.is_prime    = prime;
        res.seq_error   = seq_err;
        return res;
    endfunction

    // Offer one candidate, wait for its transfer and record what it must produce.
    task automatic send_candidate(input t_value cand, input logic restart_flag,
                                  input logic pinned, input t_sieve_result pinned_res);
        t_sieve_result res;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_BITS'(cand);
        s_axis_tuser  <= restart_flag;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = sieve_predict(cand, restart_flag);
        pending_results.push_back(pinned ? pinned_res : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_run(input int count);
        repeat (count) send_candidate(next_candidate, 1'b0, PREDICTED, '0);
    endtask

    // Hold the input off until every outstanding result has left the core.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // One random segment: mostly in-sequence runs, some gaps and bad restarts.
    task automatic random_segment();
        int          kind;
        logic [31:0] noise;
        kind  = $urandom_range(0, 99);
        noise = $urandom();
        if (kind < 70) begin
            send_run($urandom_range(1, 40));
        end else if (kind < 74) begin
            send_candidate(t_value'(FIRST_CANDIDATE), 1'b1, PREDICTED, '0);
            send_run($urandom_range(1, 60));
        end else if (kind < 83) begin
            // Jump anywhere in the value range, then carry on from there.
            send_candidate(noise[VALUE_BITS-1:0], 1'b0, PREDICTED, '0);
            send_run($urandom_range(1, 20));
        end else if (kind < 90) begin
            send_candidate(t_value'($urandom_range(0, 300)), 1'b0, PREDICTED, '0);
            send_run($urandom_range(1, 20));
        end else if (kind < 96) begin
            send_candidate(noise[VALUE_BITS-1:0], 1'b1, PREDICTED, '0);
            send_run($urandom_range(0, 10));
        end else begin
            // Run up to the top of the range, wrapping to zero when the run is long enough.
            send_candidate(t_value'(24'hFFFFFF - $urandom_range(0, 3)), 1'b0, PREDICTED, '0);
            send_run($urandom_range(2, 8));
        end
    endtask

    // Output ready, lowered at random on the falling edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Compare each result transfer with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_sieve_result want;
        t_sieve_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.sieve_value = m_axis_tdata[VALUE_BITS-1:0];
            got.is_prime    = m_axis_tuser[0];
            got.seq_error   = m_axis_tuser[1];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value %0d prime %0b error %0b",
                         $realtime, got.sieve_value, got.is_prime, got.seq_error);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.sieve_value !== want.sieve_value) begin
                    $display("%0t: sieve_value expected %0d actual %0d",
                             $realtime, want.sieve_value, got.sieve_value);
                    mismatch_count++;
                end
                if (got.is_prime !== want.is_prime) begin
                    $display("%0t: is_prime expected %0b actual %0b (value %0d)",
                             $realtime, want.is_prime, got.is_prime, want.sieve_value);
                    mismatch_count++;
                end
                if (got.seq_error !== want.seq_error) begin
                    $display("%0t: sequence_error expected %0b actual %0b (value %0d)",
                             $realtime, want.seq_error, got.seq_error, want.sieve_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Main stimulus.
    initial begin
        i_rst_n           = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tuser      = '0;
        mismatch_count    = 0;
        items_sent        = 0;
        stored_count      = 0;
        next_candidate    = t_value'(FIRST_CANDIDATE);
        sender_idle_pct   = 29;
        receiver_idle_pct = 58;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_table[i]) begin
            send_candidate(directed_table[i].candidate, directed_table[i].restart,
                           directed_table[i].pinned, directed_table[i].want);
        end
        drain_results();

        // Random part in three idling phases, draining between them.
        for (int phase = 0; phase < 3; phase++) begin
            int phase_end;
            if (phase == 1) begin
                sender_idle_pct   = 58;
                receiver_idle_pct = 29;
            end else if (phase == 2) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) random_segment();
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
